@@ rtl/afsk_pkg.sv @@
// ----------------------------------------------------------------------------
// AFSK tone synthesiser package
// Register map, reset values and the elaboration-time sine table generator
// shared by the synthesiser modules.
// ----------------------------------------------------------------------------
package afsk_pkg;

  localparam int unsigned ROM_DEPTH_DEF = 256;

  // Register map: index of each configuration register (byte address / 4).
  typedef enum logic [1:0] {
    REG_MARK_INC  = 2'd0,
    REG_SPACE_INC = 2'd1,
    REG_SPB       = 2'd2
  } reg_idx_t;

  localparam logic [15:0] MARK_INC_RST  = 16'd8192;
  localparam logic [15:0] SPACE_INC_RST = 16'd15019;
  localparam logic [3:0]  SPB_RST       = 4'd8;

  // Fixed-point constants for the sine table: pi in Q32, one in Q30.
  localparam logic [63:0] PI_Q32  = 64'd13493037705;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Taylor series denominators (2n)(2n+1) for n = 1 to 12.
  localparam logic [63:0] SINE_DIV [12] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // One table entry from its quadrant, the offset within the quadrant and the
  // first-quadrant angle in Q2.30. Evaluated only at elaboration.
  function automatic logic [7:0] rom_entry(input logic [63:0] quad,
                                           input logic [63:0] frac,
                                           input logic [63:0] ang);
    logic signed [63:0] s;
    logic signed [63:0] v;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic [7:0]         res;
    s    = '0;
    term = ang;
    if (frac == 64'd0) begin
      if (quad == 64'd1) begin
        s = signed'(ONE_Q30);
      end else if (quad == 64'd3) begin
        s = -signed'(ONE_Q30);
      end else begin
        s = '0;
      end
    end else begin
      s = signed'(ang);
      for (int n = 1; n <= 12; n++) begin
        term = (term * ang) >> 30;
        term = (term * ang) >> 30;
        term = term / SINE_DIV[n-1];
        if ((n % 2) == 1) begin
          s = s - signed'(term);
        end else begin
          s = s + signed'(term);
        end
      end
      if (s > signed'(ONE_Q30)) begin
        s = signed'(ONE_Q30);
      end
      if (quad >= 64'd2) begin
        s = -s;
      end
    end
    v = 64'sd127 * s;
    if (v >= 0) begin
      mag = unsigned'(v);
      res = 8'(64'd128 + (mag >> 30));
    end else begin
      mag = unsigned'(-v);
      res = 8'(64'd128 - ((mag + ONE_Q30 - 64'd1) >> 30));
    end
    return res;
  endfunction

endpackage

@@ rtl/afsk_sine_rom.sv @@
// ----------------------------------------------------------------------------
// AFSK sine ROM
// Constant table of 128 + 127*sin samples, built at elaboration, with a
// registered read port that only updates when enabled.
// ----------------------------------------------------------------------------
module afsk_sine_rom #(
  parameter int unsigned ROM_DEPTH = afsk_pkg::ROM_DEPTH_DEF,
  parameter int unsigned ADDR_W    = $clog2(ROM_DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data_r
);

  logic [7:0] rom [ROM_DEPTH];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
    localparam logic [63:0] U    = 64'(4 * k);
    localparam logic [63:0] Q    = U / ROM_DEPTH;
    localparam logic [63:0] F    = U % ROM_DEPTH;
    localparam logic [63:0] G    = Q[0] ? (64'(ROM_DEPTH) - F) : F;
    localparam logic [63:0] X    = ((afsk_pkg::PI_Q32 * G) / (64'(2 * ROM_DEPTH))
                                    + 64'd2) >> 2;
    localparam logic [7:0]  VAL  = afsk_pkg::rom_entry(Q, F, X);
    assign rom[k] = VAL;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom[rd_addr];
    end
  end

endmodule

@@ rtl/afsk_nrzi_tone_synthesizer.sv @@
// ----------------------------------------------------------------------------
// AFSK NRZI tone synthesiser
// Turns packet bytes into 8-bit DAC samples of mark and space tones.
// ----------------------------------------------------------------------------
// The in_ channel takes one packet byte per item (in_tlast marks the final
// byte of a packet). Bits go out least significant first; a 0 bit toggles
// the tone, a 1 bit keeps it. Every bit yields the programmed number of
// samples (1 to 8) on the out_ channel, so a byte produces 8 to 64 output
// items. out_tuser flags the last sample of each byte and out_tlast the last
// sample of a packet, after which phase and tone return to mark at zero.
// One sample leaves per cycle while out_tready is high: a byte occupies the
// sample sequencer until it has issued eight times the per-bit sample count,
// and the next byte is taken in the cycle its last sample is issued, so bytes
// stream without gaps. A byte's first sample passes the sequencer registers,
// the address register and the registered ROM read before it reaches out_.
// When out_tready is low the output register holds and the stall propagates
// back to the sequencer and to in_tready.
// Reset (synchronous) empties the pipeline, restores the register defaults
// and sets the tone to mark with phase zero. Registers on cfg_ should only
// be written while no samples are outstanding.
// ----------------------------------------------------------------------------
module afsk_nrzi_tone_synthesizer #(
  parameter int unsigned ROM_DEPTH = afsk_pkg::ROM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] sample
  output logic        out_tuser,  // [0] last_of_byte
  output logic        out_tlast,  // last_of_packet
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned ADDR_W = $clog2(ROM_DEPTH);
  localparam int unsigned AFULL_W = $clog2(ROM_DEPTH + 1);
  localparam int unsigned PROD_W = 16 + AFULL_W;

  // Configuration registers
  logic [15:0] mark_inc_r;
  logic [15:0] space_inc_r;
  logic [3:0]  spb_r;
  afsk_pkg::reg_idx_t reg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = afsk_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_inc_r  <= afsk_pkg::MARK_INC_RST;
      space_inc_r <= afsk_pkg::SPACE_INC_RST;
      spb_r       <= afsk_pkg::SPB_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        afsk_pkg::REG_MARK_INC:  mark_inc_r  <= cfg_pwdata[15:0];
        afsk_pkg::REG_SPACE_INC: space_inc_r <= cfg_pwdata[15:0];
        afsk_pkg::REG_SPB:       spb_r       <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      afsk_pkg::REG_MARK_INC:  cfg_prdata = {16'd0, mark_inc_r};
      afsk_pkg::REG_SPACE_INC: cfg_prdata = {16'd0, space_inc_r};
      afsk_pkg::REG_SPB:       cfg_prdata = {28'd0, spb_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Samples per bit, minus one, with zero read as one and anything above
  // eight read as eight.
  logic [2:0] spb_m1;
  always_comb begin
    if (spb_r == 4'd0) begin
      spb_m1 = 3'd0;
    end else if (spb_r >= 4'd8) begin
      spb_m1 = 3'd7;
    end else begin
      spb_m1 = 3'(spb_r - 4'd1);
    end
  end

  // Sample sequencer
  logic        busy_r,  busy_nxt;
  logic [7:0]  byte_r,  byte_nxt;
  logic        last_r,  last_nxt;
  logic [2:0]  bit_r,   bit_nxt;
  logic [2:0]  smp_r,   smp_nxt;
  logic        tone_r,  tone_nxt;    // 1 = mark
  logic [15:0] phase_r, phase_nxt;

  // Address stage and output stage
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_lob_r;
  logic              s1_lop_r;
  logic              out_valid_r;
  logic              out_lob_r;
  logic              out_lop_r;

  logic        out_adv;
  logic        s1_adv;
  logic        issue;
  logic        in_acc;
  logic        bit_end;
  logic        byte_end;
  logic [15:0] inc;
  logic [PROD_W-1:0]  prod;
  logic [AFULL_W-1:0] addr_full;
  logic [ADDR_W-1:0]  addr;

  assign out_adv  = !out_valid_r || out_tready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign issue    = busy_r && s1_adv;
  assign bit_end  = (smp_r == spb_m1);
  assign byte_end = bit_end && (bit_r == 3'd7);
  assign in_tready = !busy_r || (issue && byte_end);
  assign in_acc   = in_tvalid && in_tready;
  assign inc      = tone_r ? mark_inc_r : space_inc_r;

  assign prod      = PROD_W'(phase_r) * PROD_W'(ROM_DEPTH);
  assign addr_full = prod[PROD_W-1:16];
  assign addr      = (addr_full >= AFULL_W'(ROM_DEPTH)) ? ADDR_W'(ROM_DEPTH - 1)
                                                       : ADDR_W'(addr_full);

  always_comb begin
    busy_nxt  = busy_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    bit_nxt   = bit_r;
    smp_nxt   = smp_r;
    tone_nxt  = tone_r;
    phase_nxt = phase_r;
    if (issue) begin
      phase_nxt = phase_r + inc;
      if (!bit_end) begin
        smp_nxt = smp_r + 3'd1;
      end else begin
        smp_nxt = 3'd0;
        if (byte_end) begin
          busy_nxt = 1'b0;
          if (last_r) begin
            phase_nxt = '0;
            tone_nxt  = 1'b1;
          end
        end else begin
          bit_nxt = bit_r + 3'd1;
          // NRZI: a 0 bit toggles the tone.
          tone_nxt = byte_r[bit_r + 3'd1] ? tone_r : !tone_r;
        end
      end
    end
    // A new byte starts from the tone left by the previous one.
    if (in_acc) begin
      busy_nxt = 1'b1;
      byte_nxt = in_tdata;
      last_nxt = in_tlast;
      bit_nxt  = 3'd0;
      smp_nxt  = 3'd0;
      tone_nxt = in_tdata[0] ? tone_nxt : !tone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      tone_r  <= 1'b1;
      phase_r <= '0;
      bit_r   <= '0;
      smp_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      tone_r  <= tone_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      smp_r   <= smp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= issue;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_addr_r <= addr;
      s1_lob_r  <= byte_end;
      s1_lop_r  <= byte_end && last_r;
    end
    if (out_adv) begin
      out_lob_r <= s1_lob_r;
      out_lop_r <= s1_lop_r;
    end
  end

  afsk_sine_rom #(
    .ROM_DEPTH (ROM_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_rom (
    .clk       (clk),
    .rd_en     (out_adv && s1_valid_r),
    .rd_addr   (s1_addr_r),
    .rd_data_r (out_tdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_lob_r;
  assign out_tlast  = out_lop_r;

endmodule

@@ rtl/afsk_checker.sv @@
// ----------------------------------------------------------------------------
// AFSK synthesiser port checker
// Watches the synthesiser's streaming ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module afsk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // The pipeline is empty straight after reset.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled item is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output item changed");

  // The end of a packet is always the end of a byte.
  a_pkt_in_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("packet end without byte end");

  // A byte keeps the sequencer busy for at least eight samples.
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

endmodule

bind afsk_nrzi_tone_synthesizer afsk_checker u_afsk_checker (.*);

@@ dv/afsk_sample_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AFSK sample checker
// Watches the byte, sample and register channels of the tone synthesiser,
// predicts the DAC samples of every accepted byte and compares each accepted
// sample, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module afsk_sample_checker #(
  parameter int unsigned DEPTH = afsk_pkg::ROM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] sample
  input  logic        out_tuser,  // [0] last_of_byte
  input  logic        out_tlast,  // last_of_packet
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int unsigned mismatches,
  output int unsigned pending
);

  // Pi in Q32 and one in Q30 for the table build.
  localparam longint unsigned PI_FX    = 64'd13493037705;
  localparam longint          UNIT_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [7:0] level;
    logic       byte_end;
    logic       packet_end;
  } dac_sample_t;

  dac_sample_t expected_samples[$];
  logic [7:0]  tone_rom [DEPTH];
  logic [15:0] phase_acc;
  logic        on_mark;
  logic [15:0] mark_step;
  logic [15:0] space_step;
  logic [3:0]  spb_reg;

  // Sine table entry: first-quadrant Taylor series in Q2.30 with truncated
  // products, then 127*sin floored towards minus infinity around 128.
  function automatic logic [7:0] sine_level(input int unsigned k);
    longint unsigned quad;
    longint unsigned off;
    longint unsigned g;
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    longint          scaled;
    quad = (4 * k) / DEPTH;
    off  = (4 * k) % DEPTH;
    if (off == 0) begin
      acc = (quad == 1) ? UNIT_Q30 : (quad == 3) ? -UNIT_Q30 : 64'sd0;
    end else begin
      g    = quad[0] ? (DEPTH - off) : off;
      x    = ((PI_FX * g) / (2 * DEPTH) + 2) >> 2;
      acc  = longint'(x);
      term = x;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc > UNIT_Q30) begin
        acc = UNIT_Q30;
      end
      if (quad >= 2) begin
        acc = -acc;
      end
    end
    scaled = 127 * acc;
    if (scaled >= 0) begin
      return 8'(128 + (scaled >>> 30));
    end
    return 8'(128 - ((-scaled + UNIT_Q30 - 1) >>> 30));
  endfunction

  // Expands one byte into its NRZI-coded tone samples.
  task automatic render_byte(input logic [7:0] bits, input logic packet_done);
    int unsigned spb;
    int unsigned addr;
    logic [15:0] step;
    dac_sample_t s;
    spb = (spb_reg == 0) ? 1 : (spb_reg > 8) ? 8 : spb_reg;
    for (int b = 0; b < 8; b++) begin
      if (!bits[b]) begin
        on_mark = !on_mark;
      end
      step = on_mark ? mark_step : space_step;
      for (int j = 0; j < spb; j++) begin
        addr = (32'(phase_acc) * DEPTH) >> 16;
        if (addr >= DEPTH) begin
          addr = DEPTH - 1;
        end
        s.level      = tone_rom[addr];
        s.byte_end   = (b == 7) && (j == spb - 1);
        s.packet_end = s.byte_end && packet_done;
        expected_samples.push_back(s);
        phase_acc = phase_acc + step;
      end
    end
    if (packet_done) begin
      phase_acc = '0;
      on_mark   = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      tone_rom[k] = sine_level(k);
    end
  end

  always @(posedge clk) begin
    dac_sample_t want;
    logic [31:0] reg_value;
    if (!rst_n) begin
      mismatches = 0;
      phase_acc  = '0;
      on_mark    = 1'b1;
      mark_step  = afsk_pkg::MARK_INC_RST;
      space_step = afsk_pkg::SPACE_INC_RST;
      spb_reg    = afsk_pkg::SPB_RST;
      expected_samples.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        render_byte(in_tdata, in_tlast);
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            afsk_pkg::REG_MARK_INC:  mark_step  = cfg_pwdata[15:0];
            afsk_pkg::REG_SPACE_INC: space_step = cfg_pwdata[15:0];
            afsk_pkg::REG_SPB:       spb_reg    = cfg_pwdata[3:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[3:2])
            afsk_pkg::REG_MARK_INC:  reg_value = {16'h0, mark_step};
            afsk_pkg::REG_SPACE_INC: reg_value = {16'h0, space_step};
            afsk_pkg::REG_SPB:       reg_value = {28'h0, spb_reg};
            default:                 reg_value = cfg_prdata;
          endcase
          if (cfg_prdata !== reg_value) begin
            report_mismatch($sformatf("register read at %0d: got %0h, want %0h",
                                      cfg_paddr, cfg_prdata, reg_value));
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d arrived with none outstanding",
                                    out_tdata));
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want.level) begin
            report_mismatch($sformatf("sample level %0d, want %0d",
                                      out_tdata, want.level));
          end
          if (out_tuser !== want.byte_end) begin
            report_mismatch($sformatf("end-of-byte flag %b, want %b",
                                      out_tuser, want.byte_end));
          end
          if (out_tlast !== want.packet_end) begin
            report_mismatch($sformatf("end-of-packet flag %b, want %b",
                                      out_tlast, want.packet_end));
          end
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

@@ dv/afsk_nrzi_tone_synthesizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AFSK NRZI tone synthesiser testbench
// Drives packet bytes and register writes into the synthesiser with varying
// back-pressure on both sides; the sample checker predicts and compares.
// ----------------------------------------------------------------------------
module afsk_nrzi_tone_synthesizer_test;

  localparam logic [1:0]  REG_SPARE     = 2'd3;  // no register behind this index
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_WAIT      = 16;
  localparam int unsigned HOLD_CYCLES   = 500;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // [7:0] sample
  logic        out_tuser;  // [0] last_of_byte
  logic        out_tlast;  // last_of_packet
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_go = 1'b0;

  always #4 clk = ~clk;

  afsk_nrzi_tone_synthesizer dut (.*);

  afsk_sample_checker #(.DEPTH(afsk_pkg::ROM_DEPTH_DEF)) u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sample sink: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic packet_done);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= packet_done;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering bytes and waits until every predicted sample has left.
  task automatic finish_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_tones(input logic [15:0] mark, input logic [15:0] space,
                            input logic [3:0] spb);
    logic [31:0] wd;
    wd = $urandom;
    wd[15:0] = mark;
    reg_access(1'b1, afsk_pkg::REG_MARK_INC, wd);
    wd = $urandom;
    wd[15:0] = space;
    reg_access(1'b1, afsk_pkg::REG_SPACE_INC, wd);
    wd = $urandom;
    wd[3:0] = spb;
    reg_access(1'b1, afsk_pkg::REG_SPB, wd);
    reg_access(1'b0, afsk_pkg::REG_MARK_INC, '0);
    reg_access(1'b0, afsk_pkg::REG_SPACE_INC, '0);
    reg_access(1'b0, afsk_pkg::REG_SPB, '0);
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random packets of one to six bytes; a phase may stop mid-packet so that
  // the next register settings land between bytes of one packet.
  task automatic run_phase(input int n_items, input int unsigned tx_pct,
                           input int unsigned rx_pct, input bit squeeze);
    int   left;
    int   len;
    logic packet_done;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    load_tones(pick_step(), pick_step(), 4'($urandom_range(0, 15)));
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 6);
      if (len > left) begin
        len = left;
      end
      for (int i = 0; i < len; i++) begin
        packet_done = (i == len - 1) && !(left == 1 && $urandom_range(0, 1) == 0);
        // One cycle of request starts the long hold-off in the sink; the
        // sender then keeps offering bytes while the block fills up.
        if (squeeze && (left == n_items - 3)) begin
          in_tvalid <= 1'b0;
          hold_go   <= 1'b1;
          @(posedge clk);
          hold_go   <= 1'b0;
        end
        send_byte(8'($urandom_range(0, 255)), packet_done);
        left--;
      end
    end
    hold_go <= 1'b0;
    finish_stream();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all toggles, no toggles, alternating bits.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b1);
    finish_stream();

    // Zero samples per bit behaves as one.
    load_tones(16'd8192, 16'd15019, 4'd0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    finish_stream();

    // Oversized samples per bit saturate to eight.
    load_tones(16'd8192, 16'd15019, 4'd15);
    send_byte(8'hC3, 1'b1);
    finish_stream();
    load_tones(16'd8192, 16'd15019, 4'd9);
    send_byte(8'h3C, 1'b0);
    finish_stream();

    // New settings arrive in the middle of a packet; the all-ones step makes the
    // phase wrap on each sample from a nonzero phase and the zero step holds it.
    load_tones(16'hFFFF, 16'h0000, 4'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    finish_stream();
    load_tones(16'h0000, 16'hFFFF, 4'd8);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    finish_stream();

    // A write to an unmapped index must leave every register alone.
    reg_access(1'b1, REG_SPARE, $urandom);
    reg_access(1'b0, REG_SPARE, '0);
    load_tones(16'd1, 16'd32768, 4'd3);
    send_byte(8'h96, 1'b1);
    finish_stream();

    run_phase(60, 0, 0, 1'b0);
    run_phase(60, 59, 0, 1'b0);
    run_phase(60, 0, 59, 1'b0);
    run_phase(60, 32, 32, 1'b0);
    run_phase(60, 0, 0, 1'b1);
    run_phase(55, 59, 0, 1'b0);
    run_phase(55, 0, 59, 1'b0);
    run_phase(50, 32, 32, 1'b1);

    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
